FILE: design/bdsr_pkg.sv
// ---------------------------------------------------------------------------
// bdsr_pkg: shared types and constants for the bounded deque
// Sizes of the entry store, the operation codes and the control word that
// the top level broadcasts to every storage cell.
// ---------------------------------------------------------------------------
package bdsr_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int VALUE_W = 32;
  localparam int OP_W    = 3;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CAP_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_FIND       = 3'd4,
    OP_REMOVE     = 3'd5
  } op_t;

  typedef logic [DATA_W-1:0] entry_t;

  // Control word for one cycle, shared by all cells (qualified by success)
  typedef struct packed {
    logic   push_front;
    logic   push_back;
    logic   pop_front;
    logic   remove;
    entry_t data;
  } cell_ctl_t;

  // Sign-extend or truncate an input word into an entry
  function automatic entry_t to_entry(input logic [VALUE_W-1:0] v);
    to_entry = DATA_W'(signed'(v));
  endfunction

endpackage

FILE: design/bounded_deque_search_remove_core.sv
// ---------------------------------------------------------------------------
// bounded_deque_search_remove_core: bounded deque with search and delete
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one word carries an operation code
// (push front, push back, pop front, pop back, find, remove) and a value.
// Result channel (out_valid / out_stall): one word per input word with the
// success flag, the match position, the count and the front/back entries.
// cfg_we / cfg_wdata set the capacity (0 acts as 1, above 16 acts as 16);
// write it only while no word is in flight.
// Every operation, search and remove included, completes in the cycle it
// is accepted: all cells compare and shift in parallel. The result is
// registered, valid the next cycle. Throughput is one word per cycle while the
// receiver takes results; a single result register sets that figure.
// While the result is stalled, in_stall is high and nothing is accepted.
// Reset empties the store, clears the result register and sets the
// capacity to 16. Entries themselves are not cleared.
// ---------------------------------------------------------------------------
module bounded_deque_search_remove_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bdsr_pkg::OP_W-1:0]           in_operation,
  input  logic signed [bdsr_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_ok,
  output logic [bdsr_pkg::IDX_W-1:0]          out_match_index,
  output logic [bdsr_pkg::CNT_W-1:0]          out_count,
  output logic signed [bdsr_pkg::VALUE_W-1:0] out_front_value,
  output logic signed [bdsr_pkg::VALUE_W-1:0] out_back_value,
  output logic                                out_is_empty,
  input  logic                                cfg_we,
  input  logic [bdsr_pkg::CAP_W-1:0]          cfg_wdata
);

  localparam int D = bdsr_pkg::DEPTH;

  logic [bdsr_pkg::CAP_W-1:0] max_len_r;
  logic [bdsr_pkg::CNT_W-1:0] fill_r, fill_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_ok_r, out_ok_nxt;
  logic [bdsr_pkg::IDX_W-1:0] out_idx_r, out_idx_nxt;

  logic                       in_acc;
  logic                       ok_c;
  logic [bdsr_pkg::CNT_W-1:0] cap_c;
  logic                       has_room, not_empty, any_hit;
  logic [bdsr_pkg::IDX_W-1:0] first_idx;
  bdsr_pkg::cell_ctl_t        ctl;
  bdsr_pkg::entry_t           search_word;

  bdsr_pkg::entry_t cell_data [D];
  logic [D-1:0]     occ, tail_sel, hit, seen_in, seen_out;
  logic [bdsr_pkg::IDX_W-1:0] tail_idx;

  // Handshake
  assign in_stall = !rst_n || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  // Effective capacity
  always_comb begin
    if (max_len_r == '0) begin
      cap_c = bdsr_pkg::CNT_W'(1);
    end else if (32'(max_len_r) > D) begin
      cap_c = bdsr_pkg::CNT_W'(D);
    end else begin
      cap_c = bdsr_pkg::CNT_W'(max_len_r);
    end
  end

  assign has_room    = fill_r < cap_c;
  assign not_empty   = fill_r != '0;
  assign search_word = bdsr_pkg::to_entry(in_value);
  assign any_hit     = seen_out[D-1];

  // Success flag per operation
  always_comb begin
    case (bdsr_pkg::op_t'(in_operation))
      bdsr_pkg::OP_PUSH_FRONT: ok_c = has_room;
      bdsr_pkg::OP_PUSH_BACK:  ok_c = has_room;
      bdsr_pkg::OP_POP_FRONT:  ok_c = not_empty;
      bdsr_pkg::OP_POP_BACK:   ok_c = not_empty;
      bdsr_pkg::OP_FIND:       ok_c = any_hit;
      bdsr_pkg::OP_REMOVE:     ok_c = any_hit;
      default:                 ok_c = 1'b0;
    endcase
  end

  // Broadcast control word to the cells
  always_comb begin
    ctl.data       = search_word;
    ctl.push_front = in_acc && ok_c
                     && (in_operation == bdsr_pkg::OP_PUSH_FRONT);
    ctl.push_back  = in_acc && ok_c
                     && (in_operation == bdsr_pkg::OP_PUSH_BACK);
    ctl.pop_front  = in_acc && ok_c
                     && (in_operation == bdsr_pkg::OP_POP_FRONT);
    ctl.remove     = in_acc && ok_c
                     && (in_operation == bdsr_pkg::OP_REMOVE);
  end

  // Cell row
  for (genvar i = 0; i < D; i++) begin : g_cell
    assign occ[i]      = bdsr_pkg::CNT_W'(i) < fill_r;
    assign tail_sel[i] = bdsr_pkg::CNT_W'(i) == fill_r;
    if (i == 0) begin : g_head
      assign seen_in[i] = 1'b0;
    end else begin : g_body
      assign seen_in[i] = seen_out[i-1];
    end

    bdsr_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ[i]),
      .tail_sel   (tail_sel[i]),
      .left_data  ((i == 0) ? search_word : cell_data[(i == 0) ? 0 : i-1]),
      .right_data ((i == D-1) ? cell_data[i] : cell_data[(i == D-1) ? i : i+1]),
      .seen_in    (seen_in[i]),
      .data_out   (cell_data[i]),
      .hit_out    (hit[i]),
      .seen_out   (seen_out[i])
    );
  end

  // Position of the first match
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < D; i++) begin
      if (hit[i] && !seen_in[i]) begin
        first_idx = first_idx | bdsr_pkg::IDX_W'(i);
      end
    end
  end

  // Fill count update
  always_comb begin
    fill_nxt = fill_r;
    if (in_acc && ok_c) begin
      case (bdsr_pkg::op_t'(in_operation))
        bdsr_pkg::OP_PUSH_FRONT: fill_nxt = fill_r + 1'b1;
        bdsr_pkg::OP_PUSH_BACK:  fill_nxt = fill_r + 1'b1;
        bdsr_pkg::OP_POP_FRONT:  fill_nxt = fill_r - 1'b1;
        bdsr_pkg::OP_POP_BACK:   fill_nxt = fill_r - 1'b1;
        bdsr_pkg::OP_REMOVE:     fill_nxt = fill_r - 1'b1;
        default:                 fill_nxt = fill_r;
      endcase
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_idx_nxt   = out_idx_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = ok_c;
      out_idx_nxt   = ((in_operation == bdsr_pkg::OP_FIND)
                       || (in_operation == bdsr_pkg::OP_REMOVE)) && any_hit
                      ? first_idx : '0;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= bdsr_pkg::CAP_W'(D);
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      out_ok_r    <= 1'b0;
      out_idx_r   <= '0;
    end else begin
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      out_ok_r    <= out_ok_nxt;
      out_idx_r   <= out_idx_nxt;
    end
  end

  // Front and back read straight from the cells; state holds until next accept
  assign tail_idx        = bdsr_pkg::IDX_W'(fill_r - 1'b1);
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_match_index = out_idx_r;
  assign out_count       = fill_r;
  assign out_is_empty    = !not_empty;
  assign out_front_value = not_empty ? bdsr_pkg::VALUE_W'(cell_data[0]) : '0;
  assign out_back_value  = not_empty ? bdsr_pkg::VALUE_W'(cell_data[tail_idx]) : '0;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= D)
    else $error("fill count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ok_c && ((in_operation == bdsr_pkg::OP_PUSH_FRONT)
      || (in_operation == bdsr_pkg::OP_PUSH_BACK))
    |=> fill_r == $past(fill_r) + 1'b1)
    else $error("successful push did not grow the store");

  a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !ok_c |=> $stable(fill_r))
    else $error("failed operation changed the count");

  a_idx_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_idx_r != '0) |-> out_ok_r)
    else $error("match index reported without success");

endmodule

FILE: design/bdsr_cell.sv
// ---------------------------------------------------------------------------
// bdsr_cell: one position of the deque
// Holds one entry, compares it with the search word and shifts toward
// either neighbor. The match-seen flag ripples from front to back.
// ---------------------------------------------------------------------------
module bdsr_cell (
  input  logic               clk,
  input  bdsr_pkg::cell_ctl_t ctl,
  input  logic               occ,       // position below fill count
  input  logic               tail_sel,  // position equals fill count
  input  bdsr_pkg::entry_t   left_data,
  input  bdsr_pkg::entry_t   right_data,
  input  logic               seen_in,   // match found at an earlier position
  output bdsr_pkg::entry_t   data_out,
  output logic               hit_out,
  output logic               seen_out
);

  bdsr_pkg::entry_t data_r;
  bdsr_pkg::entry_t data_nxt;

  // Compare against the search word
  assign hit_out  = occ && (data_r == ctl.data);
  assign seen_out = seen_in || hit_out;
  assign data_out = data_r;

  // Shift or load select
  always_comb begin
    data_nxt = data_r;
    if (ctl.push_front) begin
      data_nxt = left_data;
    end else if (ctl.pop_front || (ctl.remove && seen_out)) begin
      data_nxt = right_data;
    end else if (ctl.push_back && tail_sel) begin
      data_nxt = ctl.data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

FILE: verif/bounded_deque_search_remove_core_test.sv
// ---------------------------------------------------------------------------
// bounded_deque_search_remove_core_test: self-checking bench for the deque
// A queue of pending words feeds a clocked driver. A clocked monitor checks
// each result word against an in-order list of expected results. That list
// is built from a behavioral copy of the store, updated at every accepted
// input word. The run writes several capacities, the out-of-range ones
// among them. It starts with a directed sweep of the corner cases, then
// runs random push, pop, find and remove traffic under varying back-pressure.
// ---------------------------------------------------------------------------
module bounded_deque_search_remove_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes outside the defined operation set
  localparam logic [bdsr_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [bdsr_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [bdsr_pkg::VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [bdsr_pkg::VALUE_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [bdsr_pkg::OP_W-1:0]           opc;
    logic signed [bdsr_pkg::VALUE_W-1:0] val;
  } deque_cmd_t;

  typedef struct {
    logic                         ok;
    logic [bdsr_pkg::IDX_W-1:0]   match_index;
    logic [bdsr_pkg::CNT_W-1:0]   count;
    logic [bdsr_pkg::VALUE_W-1:0] front;
    logic [bdsr_pkg::VALUE_W-1:0] back;
    logic                         is_empty;
  } deque_result_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [bdsr_pkg::OP_W-1:0]           in_operation = '0;
  logic signed [bdsr_pkg::VALUE_W-1:0] in_value = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic                                out_ok;
  logic [bdsr_pkg::IDX_W-1:0]          out_match_index;
  logic [bdsr_pkg::CNT_W-1:0]          out_count;
  logic signed [bdsr_pkg::VALUE_W-1:0] out_front_value;
  logic signed [bdsr_pkg::VALUE_W-1:0] out_back_value;
  logic                                out_is_empty;
  logic                                cfg_we = 1'b0;
  logic [bdsr_pkg::CAP_W-1:0]          cfg_wdata = '0;

  deque_cmd_t    pending_cmds[$];
  deque_result_t expected_results[$];
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            error_count = 0;

  // Shadow copy of the store and the capacity register
  bdsr_pkg::entry_t           shadow_store[bdsr_pkg::DEPTH];
  int                         shadow_fill = 0;
  logic [bdsr_pkg::CAP_W-1:0] shadow_max_len = 5'd16;

  bounded_deque_search_remove_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_match_index (out_match_index),
    .out_count       (out_count),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_is_empty    (out_is_empty),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one word to the shadow store and return the result it should give
  function automatic deque_result_t apply_word(
      input logic [bdsr_pkg::OP_W-1:0] opc,
      input logic signed [bdsr_pkg::VALUE_W-1:0] val);
    deque_result_t    r;
    bdsr_pkg::entry_t w;
    int               hit;
    int               limit;
    r     = '{default: '0};
    w     = val;
    hit   = -1;
    limit = (shadow_max_len == 0) ? 1 :
            (shadow_max_len > bdsr_pkg::DEPTH) ? bdsr_pkg::DEPTH : int'(shadow_max_len);
    for (int i = shadow_fill - 1; i >= 0; i--)
      if (shadow_store[i] == w) hit = i;

    case (opc)
      bdsr_pkg::OP_PUSH_FRONT: if (shadow_fill < limit) begin
        for (int i = shadow_fill; i > 0; i--) shadow_store[i] = shadow_store[i-1];
        shadow_store[0] = w;
        shadow_fill++;
        r.ok = 1'b1;
      end
      bdsr_pkg::OP_PUSH_BACK: if (shadow_fill < limit) begin
        shadow_store[shadow_fill] = w;
        shadow_fill++;
        r.ok = 1'b1;
      end
      bdsr_pkg::OP_POP_FRONT: if (shadow_fill > 0) begin
        for (int i = 0; i < shadow_fill - 1; i++) shadow_store[i] = shadow_store[i+1];
        shadow_fill--;
        r.ok = 1'b1;
      end
      bdsr_pkg::OP_POP_BACK: if (shadow_fill > 0) begin
        shadow_fill--;
        r.ok = 1'b1;
      end
      bdsr_pkg::OP_FIND: if (hit >= 0) begin
        r.ok          = 1'b1;
        r.match_index = hit[bdsr_pkg::IDX_W-1:0];
      end
      bdsr_pkg::OP_REMOVE: if (hit >= 0) begin
        for (int i = hit; i < shadow_fill - 1; i++) shadow_store[i] = shadow_store[i+1];
        shadow_fill--;
        r.ok          = 1'b1;
        r.match_index = hit[bdsr_pkg::IDX_W-1:0];
      end
      default: ;  // spare codes leave the store alone
    endcase

    r.count    = shadow_fill[bdsr_pkg::CNT_W-1:0];
    r.is_empty = (shadow_fill == 0);
    if (shadow_fill > 0) begin
      r.front = shadow_store[0][bdsr_pkg::VALUE_W-1:0];
      r.back  = shadow_store[shadow_fill-1][bdsr_pkg::VALUE_W-1:0];
    end
    return r;
  endfunction

  task automatic flag_error(input string what, input logic [31:0] got,
                            input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // Driver: predict on acceptance, then present the next word or idle
  always @(posedge clk) begin : drive_words
    deque_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(apply_word(in_operation, in_value));
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          c = pending_cmds.pop_front();
          in_valid     <= 1'b1;
          in_operation <= c.opc;
          in_value     <= c.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result word, then pick the next stall
  always @(posedge clk) begin : check_results
    deque_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        flag_error("unexpected result word", 32'(out_count), 32'(0));
      end else begin
        want = expected_results.pop_front();
        if (out_ok !== want.ok) flag_error("ok", 32'(out_ok), 32'(want.ok));
        if (out_match_index !== want.match_index)
          flag_error("match_index", 32'(out_match_index), 32'(want.match_index));
        if (out_count !== want.count)
          flag_error("count", 32'(out_count), 32'(want.count));
        if (out_front_value !== want.front)
          flag_error("front_value", out_front_value, want.front);
        if (out_back_value !== want.back)
          flag_error("back_value", out_back_value, want.back);
        if (out_is_empty !== want.is_empty)
          flag_error("is_empty", 32'(out_is_empty), 32'(want.is_empty));
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic queue_word(input logic [bdsr_pkg::OP_W-1:0] opc,
                            input logic signed [bdsr_pkg::VALUE_W-1:0] val);
    deque_cmd_t c;
    c.opc = opc;
    c.val = val;
    pending_cmds.push_back(c);
  endtask

  // Block until every queued word went in and every result came back
  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [bdsr_pkg::CAP_W-1:0] v);
    @(posedge clk);
    cfg_we         <= 1'b1;
    cfg_wdata      <= v;
    shadow_max_len  = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus
  initial begin : stimulus
    logic [bdsr_pkg::CAP_W-1:0]          caps[8];
    logic signed [bdsr_pkg::VALUE_W-1:0] value_pool[8];
    logic [bdsr_pkg::OP_W-1:0]           opc;
    logic signed [bdsr_pkg::VALUE_W-1:0] val;
    int                                  r;
    bit                                  filling;
    deque_result_t                       left_over;

    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd3, 5'd16, 5'd12};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners at a capacity of two
    write_max_len(5'd2);
    queue_word(bdsr_pkg::OP_POP_FRONT, 0);     // empty store fails
    queue_word(bdsr_pkg::OP_POP_BACK, 0);
    queue_word(bdsr_pkg::OP_FIND, 0);
    queue_word(bdsr_pkg::OP_REMOVE, 0);
    queue_word(bdsr_pkg::OP_PUSH_BACK, WORD_MIN);
    queue_word(bdsr_pkg::OP_PUSH_FRONT, WORD_MAX);
    queue_word(bdsr_pkg::OP_PUSH_BACK, -1);    // full: refused
    queue_word(bdsr_pkg::OP_PUSH_FRONT, 0);
    queue_word(bdsr_pkg::OP_FIND, WORD_MAX);
    queue_word(bdsr_pkg::OP_FIND, WORD_MIN);
    queue_word(bdsr_pkg::OP_FIND, 0);          // no match
    queue_word(OP_SPARE_6, -1);
    queue_word(OP_SPARE_7, 0);
    queue_word(bdsr_pkg::OP_REMOVE, WORD_MIN); // tail
    queue_word(bdsr_pkg::OP_REMOVE, WORD_MAX); // head, store empties
    queue_word(bdsr_pkg::OP_PUSH_BACK, 5);
    queue_word(bdsr_pkg::OP_POP_BACK, 0);      // last entry
    queue_word(bdsr_pkg::OP_PUSH_FRONT, 5);
    queue_word(bdsr_pkg::OP_PUSH_BACK, 5);
    queue_word(bdsr_pkg::OP_REMOVE, 5);        // first of two matches
    queue_word(bdsr_pkg::OP_POP_FRONT, 0);     // last entry
    queue_word(bdsr_pkg::OP_PUSH_FRONT, -1);
    queue_word(bdsr_pkg::OP_POP_FRONT, 0);
    wait_drained();

    // Random phases: three back-pressure regimes over eight capacities
    for (int p = 0; p < 8; p++) begin
      case (p / 3)
        0:       begin send_idle_pct = 13; recv_idle_pct = 55; end
        1:       begin send_idle_pct = 55; recv_idle_pct = 13; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      write_max_len(caps[p]);
      // small pool so that finds and removes hit, duplicates included
      value_pool = '{WORD_MIN, WORD_MAX, 0, -1, $urandom, $urandom,
                     $urandom_range(3), $urandom_range(3)};
      for (int n = 0; n < 130; n++) begin
        filling = ((n / 24) % 2 == 0);
        r = $urandom_range(99);
        if (r < 2)
          opc = (r == 0) ? OP_SPARE_6 : OP_SPARE_7;
        else if (r < 42)
          opc = filling
                ? ($urandom_range(1) ? bdsr_pkg::OP_PUSH_FRONT : bdsr_pkg::OP_PUSH_BACK)
                : ($urandom_range(1) ? bdsr_pkg::OP_POP_FRONT : bdsr_pkg::OP_POP_BACK);
        else if (r < 62)
          opc = filling
                ? ($urandom_range(1) ? bdsr_pkg::OP_POP_FRONT : bdsr_pkg::OP_POP_BACK)
                : ($urandom_range(1) ? bdsr_pkg::OP_PUSH_FRONT : bdsr_pkg::OP_PUSH_BACK);
        else if (r < 81)
          opc = bdsr_pkg::OP_FIND;
        else
          opc = bdsr_pkg::OP_REMOVE;
        val = ($urandom_range(9) < 6) ? value_pool[$urandom_range(7)] : $urandom;
        queue_word(opc, val);
      end
      wait_drained();
    end

    repeat (5) @(posedge clk);
    while (expected_results.size() > 0) begin
      left_over = expected_results.pop_front();
      flag_error("missing result word", 32'(left_over.count), 32'(0));
    end
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog
  initial begin
    #1ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
